// ===== hw/rtl/smallest_free_number_allocator_unit_assert.svh =====
// Assertion macros for the checker file of the allocator.
// Every macro samples on the rising edge of clk and is switched off while rst is high.
`ifndef SMALLEST_FREE_NUMBER_ALLOCATOR_UNIT_ASSERT_SVH
`define SMALLEST_FREE_NUMBER_ALLOCATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFNA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFNA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sfna_pkg.sv =====
package sfna_pkg;

  // Width of the number and value fields.
  localparam int VALUE_W = 11;

  // Action codes of an input item.
  localparam logic ACT_POP = 1'b0;
  localparam logic ACT_ADD = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP_ROOT,
    ST_POP_LAST,
    ST_SD_ISSUE,
    ST_SD_LEFT,
    ST_SD_RIGHT,
    ST_ADD_CHK,
    ST_SU_ISSUE,
    ST_SU_PARENT,
    ST_FINISH
  } state_t;

endpackage

// ===== hw/rtl/sfna_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered read data.
module sfna_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/smallest_free_number_allocator_unit.sv =====
// Channel  | Handshake           | Payload                     | Direction
// ---------+---------------------+-----------------------------+----------
// input    | in_valid / in_stall | action, number              | in
// output   | out_valid/out_stall | value, added, exhausted     | out
//
// Each transfer in produces exactly one transfer out, in order. The heap RAM has a single
// read port, so sift-down reads the two children of an entry one after the other.
// Reset (rst, synchronous, active high) empties the heap and restarts numbering at 1.
// A finished result waits in the output register while out_stall is high, and in_stall
// stays high until that result has been loaded.
module smallest_free_number_allocator_unit #(
  parameter int VALUE_LIMIT = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         action,
  input  logic [sfna_pkg::VALUE_W-1:0] number,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sfna_pkg::VALUE_W-1:0] value,
  output logic                         added,
  output logic                         exhausted
);

  localparam int VW = sfna_pkg::VALUE_W;
  // Heap slot address width.
  localparam int AW = $clog2(VALUE_LIMIT);
  // Heap count holds 0 .. VALUE_LIMIT.
  localparam int CW = $clog2(VALUE_LIMIT + 1);
  // The fresh counter holds 1 .. VALUE_LIMIT + 1.
  localparam int FW = $clog2(VALUE_LIMIT + 2);
  // Child indexes reach 2 * VALUE_LIMIT.
  localparam int IW = AW + 2;
  // Common width for comparing numbers against the counter and the limit.
  localparam int XW = ((FW > VW) ? FW : VW) + 1;

  sfna_pkg::state_t state, state_next;

  logic [CW-1:0] heap_count, heap_count_next;
  logic [FW-1:0] next_fresh, next_fresh_next;
  logic [AW-1:0] pos, pos_next;
  logic [VW-1:0] cur, cur_next;
  logic [VW-1:0] lval, lval_next;
  logic [VW-1:0] number_q, number_q_next;
  logic [VW-1:0] res_value, res_value_next;
  logic          res_added, res_added_next;
  logic          res_exh, res_exh_next;
  logic          out_valid_next;
  logic [VW-1:0] value_next;
  logic          added_next, exhausted_next;

  // Heap RAM port signals.
  logic          heap_we;
  logic [AW-1:0] heap_waddr, heap_raddr;
  logic [VW-1:0] heap_wdata, heap_rdata;

  // Membership bitmap port signals.
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic          mem_wdata, mem_rdata;

  sfna_ram #(.WIDTH(VW), .DEPTH(VALUE_LIMIT)) u_heap_ram (
    .clk  (clk),
    .we   (heap_we),
    .waddr(heap_waddr),
    .wdata(heap_wdata),
    .raddr(heap_raddr),
    .rdata(heap_rdata)
  );

  // Bit n-1 is set while number n sits in the heap. Instead of a clearing pass after
  // reset, each entry is cleared when its number is first handed out fresh; add-back
  // only looks at numbers below the counter, so it never sees a stale entry.
  sfna_ram #(.WIDTH(1), .DEPTH(VALUE_LIMIT)) u_member_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  logic          in_xfer;
  logic [XW-1:0] number_x, number_q_x, fresh_x, limit_x, root_x;
  logic [XW-1:0] number_m1_x, number_q_m1_x, fresh_m1_x, root_m1_x;
  logic          add_ok, fresh_ok;
  logic [CW-1:0] count_dec;
  logic [IW-1:0] count_x, left_i, right_i;
  logic [AW-1:0] pos_m1, parent;
  logic [VW-1:0] dec_lv;
  logic          dec_have_r, take_l, take_r;
  logic [VW-1:0] dec_best_l;
  logic          out_free;

  assign in_stall = (state != sfna_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign number_x      = XW'(number);
  assign number_q_x    = XW'(number_q);
  assign fresh_x       = XW'(next_fresh);
  assign limit_x       = XW'(VALUE_LIMIT);
  assign root_x        = XW'(heap_rdata);
  assign number_m1_x   = number_x - XW'(1);
  assign number_q_m1_x = number_q_x - XW'(1);
  assign fresh_m1_x    = fresh_x - XW'(1);
  assign root_m1_x     = root_x - XW'(1);

  // Everything about an add-back except the duplicate check, which needs the bitmap.
  assign add_ok = (number != '0) && (number_x < fresh_x) && (number_x <= limit_x) &&
                  (heap_count < CW'(VALUE_LIMIT));
  assign fresh_ok = (fresh_x <= limit_x);

  assign count_dec = heap_count - CW'(1);
  assign count_x   = IW'(heap_count);
  assign left_i    = {1'b0, pos, 1'b1};
  assign right_i   = left_i + IW'(1);
  assign pos_m1    = pos - AW'(1);
  assign parent    = {1'b0, pos_m1[AW-1:1]};

  // Shared child compare for sift-down. Ties keep the moving entry in place and prefer
  // the left child over the right one.
  assign dec_have_r = (state == sfna_pkg::ST_SD_RIGHT);
  assign dec_lv     = dec_have_r ? lval : heap_rdata;
  assign take_l     = (dec_lv < cur);
  assign dec_best_l = take_l ? dec_lv : cur;
  assign take_r     = dec_have_r && (heap_rdata < dec_best_l);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sfna_pkg::ST_IDLE;
      heap_count <= '0;
      next_fresh <= FW'(1);
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      heap_count <= heap_count_next;
      next_fresh <= next_fresh_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos       <= pos_next;
    cur       <= cur_next;
    lval      <= lval_next;
    number_q  <= number_q_next;
    res_value <= res_value_next;
    res_added <= res_added_next;
    res_exh   <= res_exh_next;
    value     <= value_next;
    added     <= added_next;
    exhausted <= exhausted_next;
  end

  always_comb begin
    state_next      = state;
    heap_count_next = heap_count;
    next_fresh_next = next_fresh;
    pos_next        = pos;
    cur_next        = cur;
    lval_next       = lval;
    number_q_next   = number_q;
    res_value_next  = res_value;
    res_added_next  = res_added;
    res_exh_next    = res_exh;
    out_valid_next  = out_valid && out_stall;
    value_next      = value;
    added_next      = added;
    exhausted_next  = exhausted;

    heap_we    = 1'b0;
    heap_waddr = pos;
    heap_wdata = cur;
    heap_raddr = '0;
    mem_we     = 1'b0;
    mem_waddr  = fresh_m1_x[AW-1:0];
    mem_wdata  = 1'b0;
    mem_raddr  = number_m1_x[AW-1:0];

    unique case (state)
      sfna_pkg::ST_IDLE: begin
        if (in_xfer) begin
          number_q_next  = number;
          res_value_next = '0;
          res_added_next = 1'b0;
          res_exh_next   = 1'b0;
          if (action == sfna_pkg::ACT_ADD) begin
            // The bitmap read for the duplicate check is issued here.
            state_next = add_ok ? sfna_pkg::ST_ADD_CHK : sfna_pkg::ST_FINISH;
          end else if (heap_count != '0) begin
            // Heap RAM address defaults to the root.
            state_next = sfna_pkg::ST_POP_ROOT;
          end else begin
            state_next = sfna_pkg::ST_FINISH;
            if (fresh_ok) begin
              res_value_next  = fresh_x[VW-1:0];
              next_fresh_next = next_fresh + FW'(1);
              mem_we          = 1'b1;
            end else begin
              res_exh_next = 1'b1;
            end
          end
        end
      end

      sfna_pkg::ST_POP_ROOT: begin
        if (root_x < fresh_x) begin
          res_value_next  = heap_rdata;
          heap_count_next = count_dec;
          if ((heap_rdata != '0) && (root_x <= limit_x)) begin
            mem_we    = 1'b1;
            mem_waddr = root_m1_x[AW-1:0];
          end
          heap_raddr = count_dec[AW-1:0];
          state_next = (count_dec == '0) ? sfna_pkg::ST_FINISH : sfna_pkg::ST_POP_LAST;
        end else begin
          state_next = sfna_pkg::ST_FINISH;
          if (fresh_ok) begin
            res_value_next  = fresh_x[VW-1:0];
            next_fresh_next = next_fresh + FW'(1);
            mem_we          = 1'b1;
          end else begin
            res_exh_next = 1'b1;
          end
        end
      end

      sfna_pkg::ST_POP_LAST: begin
        // The last entry moves to the root and sifts down from there.
        cur_next   = heap_rdata;
        pos_next   = '0;
        state_next = sfna_pkg::ST_SD_ISSUE;
      end

      sfna_pkg::ST_SD_ISSUE: begin
        if (left_i < count_x) begin
          heap_raddr = left_i[AW-1:0];
          state_next = sfna_pkg::ST_SD_LEFT;
        end else begin
          heap_we    = 1'b1;
          state_next = sfna_pkg::ST_FINISH;
        end
      end

      sfna_pkg::ST_SD_LEFT, sfna_pkg::ST_SD_RIGHT: begin
        lval_next = heap_rdata;
        if ((state == sfna_pkg::ST_SD_LEFT) && (right_i < count_x)) begin
          heap_raddr = right_i[AW-1:0];
          state_next = sfna_pkg::ST_SD_RIGHT;
        end else begin
          heap_we = 1'b1;
          priority if (take_r) begin
            heap_wdata = heap_rdata;
            pos_next   = right_i[AW-1:0];
            state_next = sfna_pkg::ST_SD_ISSUE;
          end else if (take_l) begin
            heap_wdata = dec_lv;
            pos_next   = left_i[AW-1:0];
            state_next = sfna_pkg::ST_SD_ISSUE;
          end else begin
            state_next = sfna_pkg::ST_FINISH;
          end
        end
      end

      sfna_pkg::ST_ADD_CHK: begin
        if (mem_rdata) begin
          state_next = sfna_pkg::ST_FINISH;
        end else begin
          mem_we          = 1'b1;
          mem_waddr       = number_q_m1_x[AW-1:0];
          mem_wdata       = 1'b1;
          pos_next        = heap_count[AW-1:0];
          cur_next        = number_q;
          heap_count_next = heap_count + CW'(1);
          res_added_next  = 1'b1;
          state_next      = sfna_pkg::ST_SU_ISSUE;
        end
      end

      sfna_pkg::ST_SU_ISSUE: begin
        if (pos == '0) begin
          heap_we    = 1'b1;
          state_next = sfna_pkg::ST_FINISH;
        end else begin
          heap_raddr = parent;
          state_next = sfna_pkg::ST_SU_PARENT;
        end
      end

      sfna_pkg::ST_SU_PARENT: begin
        heap_we = 1'b1;
        if (heap_rdata <= cur) begin
          state_next = sfna_pkg::ST_FINISH;
        end else begin
          heap_wdata = heap_rdata;
          pos_next   = parent;
          state_next = sfna_pkg::ST_SU_ISSUE;
        end
      end

      sfna_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          value_next     = res_value;
          added_next     = res_added;
          exhausted_next = res_exh;
          state_next     = sfna_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = sfna_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sfna_checker.sv =====
`include "smallest_free_number_allocator_unit_assert.svh"

// Port-level checks for the allocator.
module sfna_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [sfna_pkg::VALUE_W-1:0] value,
  input logic                         added,
  input logic                         exhausted
);

  // One item at a time: the input side closes right after a transfer.
  `SFNA_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "input open after transfer")

  // A result is either a pop or an add-back, never both kinds of flag.
  `SFNA_ASSERT_NOW(a_flags_excl, out_valid, !(added && exhausted), "added and exhausted both set")

  // An exhausted pop hands out nothing.
  `SFNA_ASSERT_NOW(a_exh_zero, out_valid && exhausted, value == '0, "exhausted with nonzero value")

  // A stalled result holds until it is taken.
  `SFNA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(value), "result lost")

endmodule

bind smallest_free_number_allocator_unit sfna_checker u_sfna_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .value    (value),
  .added    (added),
  .exhausted(exhausted)
);
